[design/textured_span_texel_address_generator_assert.svh]
// Assertion macros for the textured span texel address generator checker.
// Needs nothing else; included by the checker file.
`ifndef TEXTURED_SPAN_TEXEL_ADDRESS_GENERATOR_ASSERT_SVH
`define TEXTURED_SPAN_TEXEL_ADDRESS_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TSTAG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSTAG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[design/tstag_pkg.sv]
// Shared types and constants for the textured span texel address generator.
// No dependencies; imported by the divider and the top level.
package tstag_pkg;

    localparam int NUM_W     = 56;
    localparam int DEN_W     = 32;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_WLOG = 2'd1;
    localparam logic [1:0] CFG_HLOG = 2'd2;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

[design/tstag_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tstag_pkg for widths and the request/response structs.
module tstag_divider import tstag_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DEN_W:0]       trial;
    logic                 fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        fits      = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = DIV_CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

[design/textured_span_texel_address_generator.sv]
// Top level of the textured span texel address generator: sequencer, span
// registers and output register. Depends on tstag_pkg and tstag_divider.
//
//  Channel   Direction  Handshake              Carries
//  s_*       in         s_valid / s_ready      one span per transaction
//  m_*       out        m_valid / m_ready      one texel address per transaction
//  cfg_*     in         cfg_valid / cfg_ready  register index and data
//
// A span runs three step divides and three base multiplies, then emits its
// pixels; mode 1 first runs four endpoint divides, and modes 2 and 3 run two
// perspective divides before each pixel. All divides share the one serial
// divider. The block takes a new span only when idle. Reset is synchronous
// and active low and costs no clearing pass.
// A stalled m_ready holds the current result and the whole sequencer.
module textured_span_texel_address_generator import tstag_pkg::*; #(
    parameter int MAX_SPAN     = 64,
    parameter int TEX_LOG2_MAX = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_seg_start_x,
    input  logic [11:0]        s_seg_end_x,
    input  logic [11:0]        s_draw_first_x,
    input  logic [11:0]        s_draw_last_x,
    input  logic signed [31:0] s_u_start,
    input  logic signed [31:0] s_v_start,
    input  logic [31:0]        s_w_start,
    input  logic signed [31:0] s_u_end,
    input  logic signed [31:0] s_v_end,
    input  logic [31:0]        s_w_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [19:0]        m_texel_index,
    output logic [11:0]        m_pixel_x,
    output logic               m_last_pixel,
    output logic               m_truncated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_data
);

    localparam int CNT_W = $clog2(MAX_SPAN + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PDIV = 3'd1;  // endpoint perspective divides
    localparam logic [2:0] S_SDIV = 3'd2;  // step divides by segment length
    localparam logic [2:0] S_MUL  = 3'd3;  // advance to the first drawn pixel
    localparam logic [2:0] S_XDIV = 3'd4;  // per-pixel perspective divides
    localparam logic [2:0] S_EMIT = 3'd5;

    // Configuration registers.
    logic [1:0] mode_reg;
    logic [3:0] wlog_reg, hlog_reg;

    // Sequencer and span registers.
    logic [2:0]         state_reg, state_next;
    logic [1:0]         idx_reg, idx_next;
    logic               run_reg, run_next;
    logic               neg_reg, neg_next;
    logic [11:0]        x1_reg, x1_next;
    logic signed [13:0] off_reg, off_next;
    logic [12:0]        seglen_reg, seglen_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               trunc_reg, trunc_next;
    logic               persp_reg, persp_next;
    logic [3:0]         ub_reg, ub_next, vb_reg, vb_next;
    logic signed [31:0] a_reg [4], a_next [4];
    logic [31:0]        ws_reg, ws_next, we_reg, we_next;
    logic signed [32:0] d_reg [3], d_next [3];
    logic signed [47:0] acc_reg [3], acc_next [3];
    logic [31:0]        pu_reg, pu_next, pv_reg, pv_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [19:0] tex_reg, tex_next;
    logic [11:0] px_reg, px_next;
    logic        last_reg, last_next;
    logic        trf_reg, trf_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Combinational helpers.
    logic [12:0]        span_n;
    logic               span_trunc;
    logic signed [32:0] sdiff;
    logic [32:0]        smag;
    logic signed [31:0] pnum;
    logic [31:0]        pmag, pden;
    logic signed [31:0] persp_q;
    logic signed [32:0] step_q;
    logic signed [46:0] prod;
    logic signed [47:0] base;
    logic [31:0]        uu, vv;
    logic [19:0]        umask, vmask;
    logic [31:0]        vsh;
    logic [19:0]        texel;
    logic               is_last;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] a);
        if (a > 48'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (a < -48'sd2147483648) begin
            return 32'sh80000000;
        end
        return a[31:0];
    endfunction

    function automatic logic [31:0] clampw(input logic signed [47:0] a);
        if (a < 48'sd1) begin
            return 32'd1;
        end else if (a[47:32] != 16'd0) begin
            return 32'hFFFFFFFF;
        end
        return a[31:0];
    endfunction

    function automatic logic [3:0] clamp_log(input logic [3:0] l);
        return (32'(l) > TEX_LOG2_MAX) ? 4'(TEX_LOG2_MAX) : l;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    tstag_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // Divider operands: the numerator magnitude and the sign of the quotient
    // are chosen by the current state and operand index.
    always_comb begin
        sdiff = '0;
        pnum  = '0;
        pden  = 32'd1;
        case (idx_reg)
            2'd0:    sdiff = 33'(a_reg[2]) - 33'(a_reg[0]);
            2'd1:    sdiff = 33'(a_reg[3]) - 33'(a_reg[1]);
            default: sdiff = $signed({1'b0, we_reg}) - $signed({1'b0, ws_reg});
        endcase
        smag = sdiff[32] ? 33'(-sdiff) : sdiff;
        if (state_reg == S_PDIV) begin
            pnum = a_reg[idx_reg];
            pden = idx_reg[1] ? we_reg : ws_reg;
            if (pden == 32'd0) begin
                pden = 32'd1;
            end
        end else begin
            pnum = sat32(acc_reg[idx_reg[0]]);
            pden = clampw(acc_reg[2]);
        end
        pmag = pnum[31] ? 32'(-33'(pnum)) : pnum;

        div_req.start = 1'b0;
        div_req.num   = {pmag, 24'd0};
        div_req.den   = pden;
        neg_next      = neg_reg;
        if ((state_reg == S_PDIV || state_reg == S_SDIV || state_reg == S_XDIV)
            && !run_reg) begin
            div_req.start = 1'b1;
            if (state_reg == S_SDIV) begin
                div_req.num = NUM_W'(smag);
                div_req.den = DEN_W'(seglen_reg);
                neg_next    = sdiff[32];
            end else begin
                neg_next = pnum[31];
            end
        end
    end

    // Quotient post-processing: truncation toward zero, saturation to the
    // signed 32-bit range for perspective divides.
    always_comb begin
        if (!neg_reg) begin
            persp_q = (div_rsp.quot > NUM_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                            : div_rsp.quot[31:0];
        end else begin
            persp_q = (div_rsp.quot > NUM_W'(32'h80000000)) ? 32'sh80000000
                                                            : 32'(-div_rsp.quot[31:0]);
        end
        step_q = neg_reg ? 33'(-div_rsp.quot[32:0]) : div_rsp.quot[32:0];
    end

    // Base position at the first drawn pixel.
    always_comb begin
        prod = 47'(d_reg[idx_reg]) * 47'(off_reg);
        case (idx_reg)
            2'd0:    base = 48'(a_reg[0]) + 48'(prod);
            2'd1:    base = 48'(a_reg[1]) + 48'(prod);
            default: base = $signed({16'd0, ws_reg}) + 48'(prod);
        endcase
    end

    // Texel index from the current u and v.
    always_comb begin
        uu    = persp_reg ? pu_reg : acc_reg[0][31:0];
        vv    = persp_reg ? pv_reg : acc_reg[1][31:0];
        umask = (20'd1 << ub_reg) - 20'd1;
        vmask = ((20'd1 << vb_reg) - 20'd1) << ub_reg;
        vsh   = vv >> (5'd16 - {1'b0, ub_reg});
        texel = ({4'd0, uu[31:16]} & umask) | (vsh[19:0] & vmask);
        is_last = (k_reg == n_reg - 1'b1);
    end

    assign span_n     = {1'b0, s_draw_last_x} - {1'b0, s_draw_first_x} + 13'd1;
    assign span_trunc = 32'(span_n) > MAX_SPAN;

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        run_next     = run_reg;
        x1_next      = x1_reg;
        off_next     = off_reg;
        seglen_next  = seglen_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        trunc_next   = trunc_reg;
        persp_next   = persp_reg;
        ub_next      = ub_reg;
        vb_next      = vb_reg;
        a_next       = a_reg;
        ws_next      = ws_reg;
        we_next      = we_reg;
        d_next       = d_reg;
        acc_next     = acc_reg;
        pu_next      = pu_reg;
        pv_next      = pv_reg;
        m_valid_next = m_valid_reg;
        tex_next     = tex_reg;
        px_next      = px_reg;
        last_next    = last_reg;
        trf_next     = trf_reg;

        if (div_req.start) begin
            run_next = 1'b1;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    x1_next     = s_draw_first_x;
                    off_next    = $signed({2'b00, s_draw_first_x})
                                - $signed({2'b00, s_seg_start_x});
                    seglen_next = (s_seg_end_x >= s_seg_start_x)
                                ? {1'b0, s_seg_end_x} - {1'b0, s_seg_start_x} + 13'd1
                                : 13'd1;
                    trunc_next  = span_trunc;
                    n_next      = span_trunc ? CNT_W'(MAX_SPAN) : CNT_W'(span_n);
                    k_next      = '0;
                    persp_next  = mode_reg[1];
                    ub_next     = clamp_log(wlog_reg);
                    vb_next     = clamp_log(hlog_reg);
                    a_next[0]   = s_u_start;
                    a_next[1]   = s_v_start;
                    a_next[2]   = s_u_end;
                    a_next[3]   = s_v_end;
                    ws_next     = s_w_start;
                    we_next     = s_w_end;
                    idx_next    = 2'd0;
                    run_next    = 1'b0;
                    if (s_draw_last_x < s_draw_first_x) begin
                        state_next = S_IDLE;
                    end else if (mode_reg == 2'd1) begin
                        state_next = S_PDIV;
                    end else begin
                        state_next = S_SDIV;
                    end
                end
            end
            S_PDIV: begin
                if (div_rsp.done) begin
                    run_next         = 1'b0;
                    a_next[idx_reg]  = persp_q;
                    idx_next         = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        state_next = S_SDIV;
                    end
                end
            end
            S_SDIV: begin
                if (div_rsp.done) begin
                    run_next        = 1'b0;
                    d_next[idx_reg] = step_q;
                    if (idx_reg == 2'd2) begin
                        idx_next   = 2'd0;
                        state_next = S_MUL;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            S_MUL: begin
                acc_next[idx_reg] = base;
                if (idx_reg == 2'd2) begin
                    idx_next   = 2'd0;
                    state_next = persp_reg ? S_XDIV : S_EMIT;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            S_XDIV: begin
                if (div_rsp.done) begin
                    run_next = 1'b0;
                    if (idx_reg == 2'd0) begin
                        pu_next  = persp_q;
                        idx_next = 2'd1;
                    end else begin
                        pv_next    = persp_q;
                        idx_next   = 2'd0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    tex_next     = texel;
                    px_next      = x1_reg + 12'(k_reg);
                    last_next    = is_last;
                    trf_next     = trunc_reg;
                end else if (m_ready) begin
                    m_valid_next = 1'b0;
                    acc_next[0]  = acc_reg[0] + 48'(d_reg[0]);
                    acc_next[1]  = acc_reg[1] + 48'(d_reg[1]);
                    acc_next[2]  = acc_reg[2] + 48'(d_reg[2]);
                    k_next       = k_reg + 1'b1;
                    if (last_reg) begin
                        state_next = S_IDLE;
                    end else if (persp_reg) begin
                        state_next = S_XDIV;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        neg_reg    <= neg_next;
        x1_reg     <= x1_next;
        off_reg    <= off_next;
        seglen_reg <= seglen_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        trunc_reg  <= trunc_next;
        persp_reg  <= persp_next;
        ub_reg     <= ub_next;
        vb_reg     <= vb_next;
        a_reg      <= a_next;
        ws_reg     <= ws_next;
        we_reg     <= we_next;
        d_reg      <= d_next;
        acc_reg    <= acc_next;
        pu_reg     <= pu_next;
        pv_reg     <= pv_next;
        tex_reg    <= tex_next;
        px_reg     <= px_next;
        last_reg   <= last_next;
        trf_reg    <= trf_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            run_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            mode_reg    <= 2'd0;
            wlog_reg    <= 4'd8;
            hlog_reg    <= 4'd8;
        end else begin
            state_reg   <= state_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_MODE: mode_reg <= cfg_data[1:0];
                    CFG_WLOG: wlog_reg <= cfg_data;
                    CFG_HLOG: hlog_reg <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_texel_index = tex_reg;
    assign m_pixel_x     = px_reg;
    assign m_last_pixel  = last_reg;
    assign m_truncated   = trf_reg;

endmodule

[design/tstag_checker.sv]
// Port-level checker for the textured span texel address generator, with the
// bind that attaches it. Depends on the assertion macro header.
`include "textured_span_texel_address_generator_assert.svh"

module tstag_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [19:0] m_texel_index,
    input logic        m_last_pixel
);

    `TSTAG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_texel_index), "result changed while stalled")
    `TSTAG_ASSERT_NEXT(a_no_out_after_in, aclk, aresetn, s_valid && s_ready, !m_valid, "result present straight after an input transaction")
    `TSTAG_ASSERT_NEXT(a_busy_mid_span, aclk, aresetn, m_valid && m_ready && !m_last_pixel, !s_ready, "ready while a span is unfinished")
    `TSTAG_ASSERT_NEXT(a_one_result, aclk, aresetn, m_valid && m_ready, !m_valid, "result register not emptied after transaction")
    `TSTAG_ASSERT_NOW(a_no_out_idle, aclk, aresetn, s_ready && m_valid, m_last_pixel, "pending result while idle is not a final pixel")

endmodule

bind textured_span_texel_address_generator tstag_checker u_tstag_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_texel_index(m_texel_index),
    .m_last_pixel (m_last_pixel)
);
